[rtl/packet_header_rewrite_and_framer_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the framer checker
// ----------------------------------------------------------------------------
`ifndef PACKET_HEADER_REWRITE_AND_FRAMER_CORE_DEFINES_SVH
`define PACKET_HEADER_REWRITE_AND_FRAMER_CORE_DEFINES_SVH

// Same-cycle implication, ignored while in reset.
`define PHRF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, ignored while in reset.
`define PHRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/phrf_pkg.sv]
// ----------------------------------------------------------------------------
// phrf_pkg
// Types, constants and helpers shared by the framer modules.
// ----------------------------------------------------------------------------
package phrf_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_HUB_UPPER  = 3'd0,
        CFG_HUB_LOWER  = 3'd1,
        CFG_HUB_KNOWN  = 3'd2,
        CFG_FLAG_BYTE  = 3'd3,
        CFG_ESC_BYTE   = 3'd4,
        CFG_ESC_MASK   = 3'd5
    } t_cfg_idx;

    // Header rewrite modes
    typedef enum logic [1:0] {
        MODE_PASS = 2'd0,
        MODE_WRAP = 2'd1,
        MODE_FIX  = 2'd2
    } t_mode;

    localparam logic [7:0]  FLAGS_OR_H2    = 8'h50;
    localparam logic [1:0]  TYPE_ANNOUNCE  = 2'h1;
    localparam logic [10:0] MIN_REWRITE    = 11'd19;
    localparam logic [10:0] MIN_FIX        = 11'd35;
    localparam logic [11:0] ID_BYTES       = 12'd16;
    localparam logic [10:0] POS_MAX        = 11'd2047;
    localparam logic [10:0] FIX_FIRST      = 11'd2;
    localparam logic [10:0] FIX_LAST       = 11'd17;
    localparam logic [3:0]  ID_LAST        = 4'd15;
    // Size compares: frame size tops out at 2*2063+2, limits at 4096
    localparam int          CMP_W          = 14;
    localparam int          QUEUE_DEPTH    = 4;
    localparam int          QPTR_W         = 2;
    localparam int          QCNT_W         = 3;

    typedef struct packed {
        logic [63:0] hub_upper;
        logic [63:0] hub_lower;
        logic        hub_known;
        logic [7:0]  flag;
        logic [7:0]  esc;
        logic [7:0]  mask;
    } t_cfg;

    // One classified item for the back end
    typedef struct packed {
        logic       drop;   // single dropped result
        logic       open;   // opening flag first
        logic       body;   // one stuffed body byte
        logic [7:0] bval;
        logic       ids;    // 16 stuffed identifier bytes after the body byte
        logic       close;  // closing flag last
    } t_cmd;

    function automatic logic [7:0] id_byte(input logic [63:0] up, input logic [63:0] lo,
                                           input logic [3:0] k);
        logic [63:0] w;
        logic [5:0]  sh;
        w  = k[3] ? lo : up;
        sh = {~k[2:0], 3'b000};
        return w[sh +: 8];
    endfunction

endpackage

[rtl/packet_header_rewrite_and_framer_core.sv]
// ----------------------------------------------------------------------------
// packet_header_rewrite_and_framer_core
// Transmit framer: flag-delimited, byte-stuffed frames with hub header rewrite.
// Packet bytes enter one item per cycle while the four-entry command queue has
// room; the front end classifies each byte (frame open, header rewrite, drop,
// close) and the back end turns each command into line bytes at one result per
// clock, while the output is not stalled, through a single output register.
// An item causes this many results: 1 for a plain byte, 2 when escaped, 2-3
// for the first or the last byte of a frame and up to 4 when one byte is both,
// and up to 35 for the hops byte of a wrapped header-1 packet (its own byte
// plus 16 stuffed identifier bytes, and the closing flag if the packet ends
// there). Oversize packets give a single dropped result on their first byte
// and nothing for the rest. Configuration writes are taken every cycle and
// must only happen while the block is idle. No clearing pass after reset.
// ----------------------------------------------------------------------------
module packet_header_rewrite_and_framer_core
    import phrf_pkg::*;
#(
    parameter int TX_LIMIT   = 1024,
    parameter int WRAP_LIMIT = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // packet byte input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_packet_byte,
    input  logic [10:0] i_packet_length,
    input  logic        i_packet_end,
    // line byte output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_line_byte,
    output logic        o_frame_end,
    output logic        o_dropped,
    output logic        o_run_last
);

    t_cfg r_cfg;
    logic q_full, q_push, q_valid, q_pop;
    t_cmd f_cmd, q_cmd;

    // Config registers; indexes past the list are ignored
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hub_upper <= '0;
            r_cfg.hub_lower <= '0;
            r_cfg.hub_known <= 1'b0;
            r_cfg.flag      <= 8'd126;
            r_cfg.esc       <= 8'd125;
            r_cfg.mask      <= 8'd32;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HUB_UPPER: begin
                    r_cfg.hub_upper <= i_cfg_data;
                end
                CFG_HUB_LOWER: begin
                    r_cfg.hub_lower <= i_cfg_data;
                end
                CFG_HUB_KNOWN: begin
                    r_cfg.hub_known <= i_cfg_data[0];
                end
                CFG_FLAG_BYTE: begin
                    r_cfg.flag <= i_cfg_data[7:0];
                end
                CFG_ESC_BYTE: begin
                    r_cfg.esc <= i_cfg_data[7:0];
                end
                CFG_ESC_MASK: begin
                    r_cfg.mask <= i_cfg_data[7:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Front: position/mode tracking and classification
    phrf_front #(
        .TX_LIMIT   (TX_LIMIT),
        .WRAP_LIMIT (WRAP_LIMIT)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_packet_byte   (i_packet_byte),
        .i_packet_length (i_packet_length),
        .i_packet_end    (i_packet_end),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_cmd           (f_cmd)
    );

    // Decouples the byte input from the output stalls
    phrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // Back: one line byte per cycle into the output register unless stalled
    phrf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_line_byte (o_line_byte),
        .o_frame_end (o_frame_end),
        .o_dropped   (o_dropped),
        .o_run_last  (o_run_last)
    );

endmodule

[rtl/phrf_queue.sv]
// ----------------------------------------------------------------------------
// phrf_queue
// Small command queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
module phrf_queue
    import phrf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10: begin
                    r_count <= r_count + 1'b1;
                end
                2'b01: begin
                    r_count <= r_count - 1'b1;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

endmodule

[rtl/phrf_front.sv]
// ----------------------------------------------------------------------------
// phrf_front
// Accepts packet bytes, tracks position and rewrite mode, classifies each item.
// ----------------------------------------------------------------------------
module phrf_front
    import phrf_pkg::*;
#(
    parameter int TX_LIMIT   = 1024,
    parameter int WRAP_LIMIT = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_packet_byte,
    input  logic [10:0] i_packet_length,
    input  logic        i_packet_end,
    input  logic        i_q_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [10:0] r_pos,  n_pos;
    t_mode       r_mode, n_mode;
    logic        r_drop, n_drop;

    logic        first;
    logic        accept;
    logic        emits;
    t_mode       first_mode;
    logic [11:0] size;
    logic [CMP_W-1:0] frame_size;
    logic        drop_now;
    logic [10:0] fix_off;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign first      = (r_pos == '0);
    // Later bytes of a dropped packet cause nothing
    assign emits      = first || !r_drop;
    assign o_push     = accept && emits;
    assign fix_off    = r_pos - FIX_FIRST;

    always_comb begin
        first_mode = MODE_PASS;
        if (i_cfg.hub_known && (i_packet_length >= MIN_REWRITE)
                && (i_packet_byte[1:0] != TYPE_ANNOUNCE)) begin
            if (!i_packet_byte[6]) begin
                first_mode = MODE_WRAP;
            end else if (i_packet_length >= MIN_FIX) begin
                first_mode = MODE_FIX;
            end
        end
        size       = (first_mode == MODE_WRAP) ? ({1'b0, i_packet_length} + ID_BYTES)
                                               : {1'b0, i_packet_length};
        frame_size = CMP_W'({size, 1'b0}) + CMP_W'(2);
        drop_now   = ((first_mode == MODE_WRAP) && (CMP_W'(size) > CMP_W'(WRAP_LIMIT)))
                     || (frame_size > CMP_W'(TX_LIMIT));
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.close = i_packet_end;
        o_cmd.bval  = i_packet_byte;
        if (first) begin
            if (drop_now) begin
                o_cmd.drop  = 1'b1;
                o_cmd.close = 1'b0;
            end else begin
                o_cmd.open = 1'b1;
                o_cmd.body = 1'b1;
                if (first_mode == MODE_WRAP) begin
                    o_cmd.bval = i_packet_byte | FLAGS_OR_H2;
                end
            end
        end else begin
            o_cmd.body = 1'b1;
            if ((r_mode == MODE_WRAP) && (r_pos == 11'd1)) begin
                o_cmd.ids = 1'b1;
            end else if ((r_mode == MODE_FIX) && (r_pos >= FIX_FIRST)
                         && (r_pos <= FIX_LAST)) begin
                o_cmd.bval = id_byte(i_cfg.hub_upper, i_cfg.hub_lower, fix_off[3:0]);
            end
        end
    end

    always_comb begin
        n_pos  = r_pos;
        n_mode = r_mode;
        n_drop = r_drop;
        if (accept) begin
            if (first) begin
                n_mode = first_mode;
                n_drop = drop_now;
            end
            if (i_packet_end) begin
                n_pos  = '0;
                n_mode = MODE_PASS;
                n_drop = 1'b0;
            end else if (r_pos < POS_MAX) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_mode <= MODE_PASS;
            r_drop <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_mode <= n_mode;
            r_drop <= n_drop;
        end
    end

endmodule

[rtl/phrf_back.sv]
// ----------------------------------------------------------------------------
// phrf_back
// Expands commands into stuffed line bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module phrf_back
    import phrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_line_byte,
    output logic       o_frame_end,
    output logic       o_dropped,
    output logic       o_run_last
);

    typedef struct packed {
        logic       drop;
        logic       open;
        logic       half;   // second byte of an escape pair pending
        logic [7:0] hval;
        logic       body;
        logic [7:0] bval;
        logic       ids;
        logic [3:0] cnt;
        logic       close;
    } t_work;

    t_work      r_work, n_work;
    logic       busy;
    t_work      cur;
    logic       can_emit;
    logic       emit;
    logic [7:0] sbyte;
    logic       special;
    logic [7:0] e_byte;
    logic       e_fe, e_dr;

    logic       r_ov;
    logic [7:0] r_byte;
    logic       r_fe, r_dr, r_last;

    assign busy     = r_work.drop | r_work.open | r_work.half | r_work.body
                      | r_work.ids | r_work.close;
    assign can_emit = !r_ov || i_out_ready;
    assign emit     = can_emit && (busy || i_q_valid);
    assign o_pop    = emit && !busy;

    always_comb begin
        cur = r_work;
        if (!busy) begin
            cur       = '0;
            cur.drop  = i_q_cmd.drop;
            cur.open  = i_q_cmd.open;
            cur.body  = i_q_cmd.body;
            cur.bval  = i_q_cmd.bval;
            cur.ids   = i_q_cmd.ids;
            cur.close = i_q_cmd.close;
        end
    end

    // Order: drop | open flag | escape tail | body | id bytes | close flag
    always_comb begin
        n_work  = cur;
        e_byte  = '0;
        e_fe    = 1'b0;
        e_dr    = 1'b0;
        sbyte   = cur.body ? cur.bval : id_byte(i_cfg.hub_upper, i_cfg.hub_lower, cur.cnt);
        special = (sbyte == i_cfg.flag) || (sbyte == i_cfg.esc);
        if (cur.drop) begin
            e_dr         = 1'b1;
            n_work.drop  = 1'b0;
        end else if (cur.open) begin
            e_byte       = i_cfg.flag;
            n_work.open  = 1'b0;
        end else if (cur.half) begin
            e_byte       = cur.hval;
            n_work.half  = 1'b0;
        end else if (cur.body || cur.ids) begin
            e_byte = special ? i_cfg.esc : sbyte;
            if (special) begin
                n_work.half = 1'b1;
                n_work.hval = sbyte ^ i_cfg.mask;
            end
            if (cur.body) begin
                n_work.body = 1'b0;
            end else begin
                n_work.cnt = cur.cnt + 1'b1;
                if (cur.cnt == ID_LAST) begin
                    n_work.ids = 1'b0;
                end
            end
        end else begin
            e_byte       = i_cfg.flag;
            e_fe         = 1'b1;
            n_work.close = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (emit) begin
                r_work <= n_work;
                r_ov   <= 1'b1;
            end else if (i_out_ready) begin
                r_ov   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= e_byte;
            r_fe   <= e_fe;
            r_dr   <= e_dr;
            r_last <= !(n_work.drop | n_work.open | n_work.half | n_work.body
                        | n_work.ids | n_work.close);
        end
    end

    assign o_out_valid = r_ov;
    assign o_line_byte = r_byte;
    assign o_frame_end = r_fe;
    assign o_dropped   = r_dr;
    assign o_run_last  = r_last;

endmodule

[rtl/phrf_checker.sv]
// ----------------------------------------------------------------------------
// phrf_checker
// Port-level checks on the framer output, bound to the top level.
// ----------------------------------------------------------------------------
`include "packet_header_rewrite_and_framer_core_defines.svh"

module phrf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_line_byte,
    input logic       i_frame_end,
    input logic       i_dropped,
    input logic       i_run_last
);

    // stalled item holds
    `PHRF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_line_byte) && $stable(i_run_last))
    // a drop is a lone zero result
    `PHRF_ASSERT_NOW(a_drop_alone, i_clk, i_rst_n, i_out_valid && i_dropped, i_run_last && !i_frame_end && (i_line_byte == 8'd0))
    // closing flag is always the last result of its item
    `PHRF_ASSERT_NOW(a_close_last, i_clk, i_rst_n, i_out_valid && i_frame_end, i_run_last)

endmodule

bind packet_header_rewrite_and_framer_core phrf_checker u_phrf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_line_byte (o_line_byte),
    .i_frame_end (o_frame_end),
    .i_dropped   (o_dropped),
    .i_run_last  (o_run_last)
);

[tb/packet_header_rewrite_and_framer_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_header_rewrite_and_framer_core_test
// Self-checking bench for the HDLC-style transmit framer. Packet bytes and
// register writes come from one queue of pending work that the stimulus block
// fills. A clocked driver feeds that work into the block and predicts the line
// bytes of each accepted item. A clocked monitor stalls the output at random
// and compares every line byte against the oldest prediction.
// ----------------------------------------------------------------------------
module packet_header_rewrite_and_framer_core_test;
    import phrf_pkg::*;

    localparam int TX_LIMIT    = 1024;
    localparam int WRAP_LIMIT  = 512;
    localparam int CFG_SETTLE  = 16;        // quiet cycles before a register write
    localparam int END_SETTLE  = 64;        // quiet cycles before the verdict
    localparam int TIMEOUT_NS  = 20000000;  // watchdog timeout
    localparam int PHASE_ITEMS = 22;

    // Hub identifier fill styles for a register phase
    localparam int ID_MIXED = 0;
    localparam int ID_ONES  = 1;
    localparam int ID_ZEROS = 2;

    typedef enum logic [1:0] {
        ACT_BYTE,   // one packet byte
        ACT_CFG,    // one register write, issued only when the block is idle
        ACT_DRAIN   // hold the sender until every line byte has come
    } t_act_kind;

    typedef struct packed {
        t_act_kind   kind;
        logic [7:0]  gap;       // idle cycles before the byte is offered
        logic [7:0]  pbyte;
        logic [10:0] plen;
        logic        pend;
        t_cfg_idx    idx;
        logic [63:0] data;
    } t_action;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       frame_end;
        logic       dropped;
        logic       run_last;
    } t_line_result;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index     = CFG_HUB_UPPER;
    logic [63:0] i_cfg_data      = '0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_packet_byte   = '0;
    logic [10:0] i_packet_length = '0;
    logic        i_packet_end    = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready     = 1'b0;
    logic [7:0]  o_line_byte;
    logic        o_frame_end;
    logic        o_dropped;
    logic        o_run_last;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    packet_header_rewrite_and_framer_core #(
        .TX_LIMIT   (TX_LIMIT),
        .WRAP_LIMIT (WRAP_LIMIT)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_packet_byte   (i_packet_byte),
        .i_packet_length (i_packet_length),
        .i_packet_end    (i_packet_end),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_line_byte     (o_line_byte),
        .o_frame_end     (o_frame_end),
        .o_dropped       (o_dropped),
        .o_run_last      (o_run_last)
    );

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    t_action      pending[$];       // work not yet offered to the block
    t_line_result line_expect[$];   // predicted line bytes, oldest first
    int           fail_count = 0;

    // Framer copy: registers as the block should hold them
    logic [63:0] hub_upper = '0;
    logic [63:0] hub_lower = '0;
    logic        hub_known = 1'b0;
    logic [7:0]  flag_byte = 8'h7e;
    logic [7:0]  esc_byte  = 8'h7d;
    logic [7:0]  esc_mask  = 8'h20;

    // Framer copy: per-packet state
    logic [10:0] frame_pos      = '0;
    t_mode       frame_mode     = MODE_PASS;
    logic        frame_dropping = 1'b0;

    // Special bytes of the phase being generated, so bodies hit them often
    logic [7:0] gen_flag = 8'h7e;
    logic [7:0] gen_esc  = 8'h7d;

    // ------------------------------------------------------------------------
    // Framer prediction
    // ------------------------------------------------------------------------
    function automatic logic [7:0] hub_byte(input int k);
        logic [127:0] ident;
        ident = {hub_upper, hub_lower};
        return ident[127 - 8 * k -: 8];
    endfunction

    function automatic void line_push(input logic [7:0] b, input logic fe, input logic dr);
        t_line_result r;
        r.line_byte = b;
        r.frame_end = fe;
        r.dropped   = dr;
        r.run_last  = 1'b0;
        line_expect.insert(line_expect.size(), r);
    endfunction

    // Flag and escape bytes go out as escape, then byte XOR mask
    function automatic void stuff_push(input logic [7:0] b);
        if (b == flag_byte || b == esc_byte) begin
            line_push(esc_byte, 1'b0, 1'b0);
            line_push(b ^ esc_mask, 1'b0, 1'b0);
        end else begin
            line_push(b, 1'b0, 1'b0);
        end
    endfunction

    // Line bytes caused by one accepted packet byte; appended to line_expect
    function automatic void frame_predict(input logic [7:0] pb, input logic [10:0] plen,
                                          input logic pend);
        int unsigned  frame_size;
        logic         oversize;
        int           first_new;
        first_new = line_expect.size();
        if (frame_pos == '0) begin
            // First byte: pick the rewrite and size the frame
            frame_mode     = MODE_PASS;
            frame_dropping = 1'b0;
            frame_size     = 32'(plen);
            oversize       = 1'b0;
            if (hub_known && plen >= MIN_REWRITE && pb[1:0] != TYPE_ANNOUNCE) begin
                if (!pb[6])
                    frame_mode = MODE_WRAP;
                else if (plen >= MIN_FIX)
                    frame_mode = MODE_FIX;
            end
            if (frame_mode == MODE_WRAP) begin
                frame_size = plen + ID_BYTES;
                if (frame_size > WRAP_LIMIT)
                    oversize = 1'b1;
            end
            if (frame_size * 2 + 2 > TX_LIMIT)
                oversize = 1'b1;
            if (oversize) begin
                frame_dropping = 1'b1;
                line_push(8'h00, 1'b0, 1'b1);
            end else begin
                line_push(flag_byte, 1'b0, 1'b0);
                stuff_push(frame_mode == MODE_WRAP ? (pb | FLAGS_OR_H2) : pb);
            end
        end else if (!frame_dropping) begin
            if (frame_mode == MODE_WRAP && frame_pos == 11'd1) begin
                // hops byte, then the identifier is inserted
                stuff_push(pb);
                for (int k = 0; k < ID_BYTES; k++)
                    stuff_push(hub_byte(k));
            end else if (frame_mode == MODE_FIX && frame_pos >= FIX_FIRST
                         && frame_pos <= FIX_LAST) begin
                stuff_push(hub_byte(int'(frame_pos - FIX_FIRST)));
            end else begin
                stuff_push(pb);
            end
        end

        if (pend && !frame_dropping)
            line_push(flag_byte, 1'b1, 1'b0);

        if (pend) begin
            frame_pos      = '0;
            frame_mode     = MODE_PASS;
            frame_dropping = 1'b0;
        end else if (frame_pos < POS_MAX) begin
            frame_pos = frame_pos + 11'd1;
        end

        if (line_expect.size() > first_new)
            line_expect[line_expect.size() - 1].run_last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Mostly short idles, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    // Body bytes lean on the special bytes and the extremes
    function automatic logic [7:0] body_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return gen_flag;
        else if (r < 40)
            return gen_esc;
        else if (r < 45)
            return 8'h00;
        else if (r < 50)
            return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void cfg_write(input t_cfg_idx idx, input logic [63:0] v);
        t_action a;
        a      = '0;
        a.kind = ACT_CFG;
        a.idx  = idx;
        a.data = v;
        pending.insert(pending.size(), a);
    endfunction

    function automatic logic [63:0] id_word(input int style);
        logic [63:0] w;
        for (int k = 0; k < 8; k++)
            w[8 * k +: 8] = (style == ID_ONES) ? 8'hff :
                            (style == ID_ZEROS) ? 8'h00 : body_byte();
        return w;
    endfunction

    // One setting of all six registers
    function automatic void phase_config(input logic known, input logic [7:0] flag,
                                         input logic [7:0] esc, input logic [7:0] mask,
                                         input int style);
        gen_flag = flag;
        gen_esc  = esc;
        cfg_write(CFG_FLAG_BYTE, {56'd0, flag});
        cfg_write(CFG_ESC_BYTE, {56'd0, esc});
        cfg_write(CFG_ESC_MASK, {56'd0, mask});
        cfg_write(CFG_HUB_UPPER, id_word(style));
        cfg_write(CFG_HUB_LOWER, id_word(style));
        cfg_write(CFG_HUB_KNOWN, {63'd0, known});
    endfunction

    // One packet: header byte, then count - 1 body bytes; end on the last one
    function automatic void packet_push(input logic [7:0] head, input logic [10:0] len,
                                        input int count, input bit burst);
        t_action a;
        for (int i = 0; i < count; i++) begin
            a       = '0;
            a.kind  = ACT_BYTE;
            a.pbyte = (i == 0) ? head : body_byte();
            a.plen  = len;
            a.pend  = (i == count - 1);
            a.gap   = (burst || $urandom_range(0, 1) == 0) ? 8'd0 : 8'(idle_len());
            pending.insert(pending.size(), a);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers pending work, predicts on every accepted item
    // ------------------------------------------------------------------------
    int gap_count = 0;
    int quiet     = 0;  // cycles with nothing expected and nothing offered

    always @(posedge i_clk) begin : byte_driver
        logic    nxt_in_valid;
        logic    nxt_cfg_valid;
        t_action act;
        if (!i_rst_n) begin
            i_in_valid      <= 1'b0;
            i_packet_byte   <= '0;
            i_packet_length <= '0;
            i_packet_end    <= 1'b0;
            i_cfg_valid     <= 1'b0;
            i_cfg_index     <= CFG_HUB_UPPER;
            i_cfg_data      <= '0;
            hub_upper       = '0;
            hub_lower       = '0;
            hub_known       = 1'b0;
            flag_byte       = 8'h7e;
            esc_byte        = 8'h7d;
            esc_mask        = 8'h20;
            frame_pos       = '0;
            frame_mode      = MODE_PASS;
            frame_dropping  = 1'b0;
            gap_count       = 0;
            quiet           = 0;
        end else begin
            nxt_in_valid  = i_in_valid;
            nxt_cfg_valid = i_cfg_valid;

            if (i_in_valid && o_in_ready) begin
                frame_predict(i_packet_byte, i_packet_length, i_packet_end);
                nxt_in_valid = 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HUB_UPPER: hub_upper = i_cfg_data;
                    CFG_HUB_LOWER: hub_lower = i_cfg_data;
                    CFG_HUB_KNOWN: hub_known = i_cfg_data[0];
                    CFG_FLAG_BYTE: flag_byte = i_cfg_data[7:0];
                    CFG_ESC_BYTE:  esc_byte  = i_cfg_data[7:0];
                    CFG_ESC_MASK:  esc_mask  = i_cfg_data[7:0];
                    default: ;
                endcase
                nxt_cfg_valid = 1'b0;
            end

            if (line_expect.size() == 0 && !i_in_valid && !i_cfg_valid)
                quiet = quiet + 1;
            else
                quiet = 0;

            if (!nxt_in_valid && !nxt_cfg_valid && pending.size() != 0) begin
                act = pending[0];
                case (act.kind)
                    ACT_BYTE: begin
                        if (gap_count >= act.gap) begin
                            act             = pending.pop_front();
                            nxt_in_valid    = 1'b1;
                            i_packet_byte   <= act.pbyte;
                            i_packet_length <= act.plen;
                            i_packet_end    <= act.pend;
                            gap_count       = 0;
                        end else begin
                            gap_count = gap_count + 1;
                        end
                    end
                    ACT_CFG: begin
                        // swallowed bytes of a dropped packet leave no trace, so
                        // also let a few quiet cycles pass before the write
                        if (quiet >= CFG_SETTLE) begin
                            act           = pending.pop_front();
                            nxt_cfg_valid = 1'b1;
                            i_cfg_index   <= act.idx;
                            i_cfg_data    <= act.data;
                        end
                    end
                    ACT_DRAIN: begin
                        if (line_expect.size() == 0)
                            act = pending.pop_front();
                    end
                    default: begin
                        act = pending.pop_front();
                    end
                endcase
            end

            i_in_valid  <= nxt_in_valid;
            i_cfg_valid <= nxt_cfg_valid;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random output stalls, line byte check
    // ------------------------------------------------------------------------
    int stall_left   = 0;
    int stretch_left = 0;
    bit calm         = 1'b0;    // stretch with ready held high

    always @(posedge i_clk) begin : line_monitor
        t_line_result want;
        logic         nxt_ready;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left   = 0;
            stretch_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (line_expect.size() == 0) begin
                    $error("unexpected line byte %02h", o_line_byte);
                    fail_count++;
                end else begin
                    want = line_expect.pop_front();
                    // line_byte carries nothing in a dropped item
                    if (!want.dropped && o_line_byte !== want.line_byte) begin
                        $error("line_byte: expected %02h, got %02h",
                               want.line_byte, o_line_byte);
                        fail_count++;
                    end
                    if (o_frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0b, got %0b",
                               want.frame_end, o_frame_end);
                        fail_count++;
                    end
                    if (o_dropped !== want.dropped) begin
                        $error("dropped: expected %0b, got %0b", want.dropped, o_dropped);
                        fail_count++;
                    end
                    if (o_run_last !== want.run_last) begin
                        $error("run_last: expected %0b, got %0b",
                               want.run_last, o_run_last);
                        fail_count++;
                    end
                end
            end

            if (stretch_left == 0) begin
                stretch_left = $urandom_range(50, 300);
                calm         = ($urandom_range(0, 2) == 0);
            end else begin
                stretch_left = stretch_left - 1;
            end

            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                nxt_ready  = 1'b0;
            end else begin
                nxt_ready = 1'b1;
                if (!calm && $urandom_range(0, 99) < 30)
                    stall_left = idle_len();
            end
            i_out_ready <= nxt_ready;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0]  head;
        logic [10:0] len;
        int          count;
        int          n_items;
        int          r;
        bit          drained;
        t_action     drain_act;

        // Reset values of the registers, hub not yet known
        packet_push(8'h7e, 11'd1, 1, 1'b1);      // lone byte equal to the flag
        packet_push(8'h7d, 11'd0, 2, 1'b1);      // zero length
        packet_push(8'h01, 11'd20, 2, 1'b0);     // announce before hub known
        packet_push(8'hff, 11'd512, 2, 1'b0);    // plain oversize, tail swallowed
        packet_push(8'h00, 11'd511, 1, 1'b0);    // largest plain frame that fits

        phase_config(1'b1, 8'h7e, 8'h7d, 8'h20, ID_MIXED);
        packet_push(8'h00, 11'd19, 4, 1'b0);     // shortest header-1 wrap
        packet_push(8'h42, 11'd35, 4, 1'b0);     // shortest header-2 fix, ends early
        packet_push(8'h01, 11'd40, 2, 1'b0);     // announce never rewritten
        packet_push(8'h40, 11'd34, 2, 1'b0);     // header-2 one byte short of fix
        packet_push(8'h02, 11'd495, 2, 1'b0);    // largest wrap that fits
        packet_push(8'h03, 11'd496, 1, 1'b0);    // wrap oversize, ends on first byte
        packet_push(8'h40, 11'd1024, 1, 1'b0);   // length 1024, oversize

        // Random phases, each under its own register setting
        drained = 1'b0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: phase_config(1'b1, 8'h7e, 8'h7d, 8'h20, ID_MIXED);
                1: phase_config(1'b1, 8'h00, 8'hff, 8'hff, ID_ONES);
                2: phase_config($urandom_range(0, 3) != 0, 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                ID_MIXED);
                default: phase_config(1'b1, 8'hff, 8'h00, 8'h00, ID_ZEROS);
            endcase
            n_items = 0;
            while (n_items < PHASE_ITEMS) begin
                // header byte: mostly rewrite candidates
                head = 8'($urandom_range(0, 255));
                r    = $urandom_range(0, 99);
                if (r < 70) begin
                    head[6]   = (r >= 40);
                    head[1:0] = ($urandom_range(0, 2) == 0) ? 2'd0 : 2'($urandom_range(2, 3));
                end else if (r < 85) begin
                    head[1:0] = TYPE_ANNOUNCE;
                end

                r = $urandom_range(0, 99);
                if (r < 65)
                    len = 11'($urandom_range(19, 45));
                else if (r < 80)
                    len = 11'($urandom_range(1, 18));
                else if (r < 92)
                    len = 11'($urandom_range(490, 520));
                else
                    len = 11'($urandom_range(1000, 1024));

                // full packets, early ends and overlong ones
                if (len <= 45 && $urandom_range(0, 1) == 0)
                    count = int'(len);
                else
                    count = $urandom_range(1, (len <= 45) ? len + 4 : 24);
                // keep the phase near its item budget; a cut packet just ends early
                if (count > PHASE_ITEMS - n_items)
                    count = PHASE_ITEMS - n_items;

                packet_push(head, len, count, $urandom_range(0, 3) == 0);
                n_items += count;

                if (ph == 1 && !drained && n_items >= PHASE_ITEMS / 2) begin
                    drain_act      = '0;
                    drain_act.kind = ACT_DRAIN;
                    pending.insert(pending.size(), drain_act);
                    drained = 1'b1;
                end
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || i_in_valid || i_cfg_valid || line_expect.size() != 0)
            @(posedge i_clk);
        repeat (END_SETTLE) @(posedge i_clk);

        if (fail_count == 0)
            $display("packet_header_rewrite_and_framer_core_test: clean");
        else
            $display("packet_header_rewrite_and_framer_core_test: errors");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("packet_header_rewrite_and_framer_core_test: errors");
        $finish;
    end

endmodule
